[src/wma_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted mean accumulator package
// Shared widths, the job record passed from the accumulator to the divider,
// and the divider state codes.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int IN_W       = 32;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_W      = 64;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int NUM_W      = ACC_W + FRAC_BITS;
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;

    typedef struct packed {
        t_acc sum;
        t_acc total;
        logic sat;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

[src/weighted_mean_accumulator.sv]
// ----------------------------------------------------------------------------
// Weighted mean accumulator
// Streams (weight, value) pairs and gives the weighted mean of each vector.
// ----------------------------------------------------------------------------
// Input side: an item is taken on a clock edge with push high and full low.
// Each item adds weight * value and weight to saturating 64-bit sums; the
// item with last set closes the vector and queues its sums for division.
// Result side: while empty is low the oldest result is on o_mean,
// o_zero_weight and o_overflowed; it is taken on an edge with pop high.
// The mean carries FRAC_BITS fraction bits and is truncated towards zero.
// Throughput: one item per cycle within a vector while full is low. The
// divider resolves one quotient bit per cycle, so short vectors are limited
// by the divider rather than by the input side.
// A two-entry queue holds finished vectors; when it is full and another
// vector closes, full rises until the divider takes a job. A stalled
// receiver holds the result register and, in turn, the divider and queue.
// Reset clears the sums, the queue and the divider; no clearing pass follows.
// ----------------------------------------------------------------------------
module weighted_mean_accumulator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [wma_pkg::IN_W-1:0]         i_weight,
    input  logic [wma_pkg::IN_W-1:0]         i_sample_value,
    input  logic                             i_last,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [wma_pkg::ACC_W-1:0] o_mean,
    output logic                             o_zero_weight,
    output logic                             o_overflowed
);
    import wma_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_job push_job, pop_job;

    wma_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_weight       (i_weight),
        .i_sample_value (i_sample_value),
        .i_last         (i_last),
        .o_full         (full),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_job        (push_job)
    );

    wma_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (pop_job),
        .o_empty (q_empty)
    );

    wma_divider u_divider (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_job         (pop_job),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_mean        (o_mean),
        .o_zero_weight (o_zero_weight),
        .o_overflowed  (o_overflowed)
    );

`ifndef SYNTH
    // A closed vector is never offered to a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("job pushed into a full queue");

    // The divider only takes a job that is there.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from an empty queue");

    // The input side stalls only because the queue is full.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> q_full)
        else $error("input stalled without a full queue");

    // A zero total weight always reports a zero mean.
    a_zero_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_zero_weight) |-> (o_mean == '0))
        else $error("zero weight with a non-zero mean");
`endif

endmodule

[src/wma_front.sv]
// ----------------------------------------------------------------------------
// Weighted mean front end
// Takes items, multiplies weight by value in a registered stage and keeps
// the saturating running sums. On the last item of a vector it hands the
// finished sums to the job queue and clears them.
// ----------------------------------------------------------------------------
module wma_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [wma_pkg::IN_W-1:0] i_weight,
    input  logic [wma_pkg::IN_W-1:0] i_sample_value,
    input  logic                    i_last,
    output logic                    o_full,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output wma_pkg::t_job           o_q_job
);
    import wma_pkg::*;

    logic  r_a_valid, r_a_last;
    t_data r_a_w, r_a_v;
    logic  r_b_valid, r_b_last;
    t_prod r_b_prod;
    t_data r_b_w;
    t_acc  r_sum, r_total;
    logic  r_sat;

    logic             en;
    logic [ACC_W:0]   sum_wide, tot_wide;
    t_acc             n_sum, n_total;
    logic             sum_ovf, tot_ovf;

    // The whole pipeline halts only while a finished vector waits for room.
    assign en     = !(r_b_valid && r_b_last && i_q_full);
    assign o_full = !en;

    always_comb begin
        sum_wide = {r_sum[ACC_W-1], r_sum} + (ACC_W+1)'(r_b_prod);
        tot_wide = {r_total[ACC_W-1], r_total} + (ACC_W+1)'(r_b_w);
        sum_ovf  = sum_wide[ACC_W] != sum_wide[ACC_W-1];
        tot_ovf  = tot_wide[ACC_W] != tot_wide[ACC_W-1];
        n_sum    = sum_ovf ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX) : sum_wide[ACC_W-1:0];
        n_total  = tot_ovf ? (tot_wide[ACC_W] ? ACC_MIN : ACC_MAX) : tot_wide[ACC_W-1:0];
    end

    assign o_q_push      = en && r_b_valid && r_b_last;
    assign o_q_job.sum   = n_sum;
    assign o_q_job.total = n_total;
    assign o_q_job.sat   = r_sat || sum_ovf || tot_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_sum     <= '0;
            r_total   <= '0;
            r_sat     <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_push;
            r_b_valid <= r_a_valid;
            if (r_b_valid) begin
                if (r_b_last) begin
                    r_sum   <= '0;
                    r_total <= '0;
                    r_sat   <= 1'b0;
                end else begin
                    r_sum   <= n_sum;
                    r_total <= n_total;
                    r_sat   <= o_q_job.sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_w    <= t_data'(i_weight[DATA_WIDTH-1:0]);
            r_a_v    <= t_data'(i_sample_value[DATA_WIDTH-1:0]);
            r_a_last <= i_last;
            r_b_prod <= r_a_w * r_a_v;
            r_b_w    <= r_a_w;
            r_b_last <= r_a_last;
        end
    end

endmodule

[src/wma_fifo.sv]
// ----------------------------------------------------------------------------
// Weighted mean job queue
// A short register queue of finished sums between the accumulator and the
// divider, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module wma_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wma_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output wma_pkg::t_job o_job,
    output logic          o_empty
);
    import wma_pkg::*;

    t_job              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FCNT_W-1:0] r_count;

    assign o_full  = r_count == FCNT_W'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[src/wma_divider.sv]
// ----------------------------------------------------------------------------
// Weighted mean divider
// Restoring division, one quotient bit a cycle, of the scaled weighted sum
// by the total weight, with sign fix-up, saturation and a result register.
// ----------------------------------------------------------------------------
module wma_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  wma_pkg::t_job              i_job,
    output logic                       o_q_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [wma_pkg::ACC_W-1:0] o_mean,
    output logic                       o_zero_weight,
    output logic                       o_overflowed
);
    import wma_pkg::*;

    t_state             r_state;
    logic [NUM_W-1:0]   r_num;
    logic [ACC_W-1:0]   r_rem, r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_neg, r_zero, r_ovf;
    logic               r_out_valid;
    t_acc               r_mean;
    logic               r_zw, r_ov;

    logic [ACC_W:0]     rem_sh, trial;
    logic               fits;
    logic [ACC_W-1:0]   mag_num, mag_den, limit, q_sat;
    logic               q_ovf, out_load;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        trial   = rem_sh - {1'b0, r_den};
        fits    = !trial[ACC_W];
        mag_num = i_job.sum[ACC_W-1] ? ACC_W'(-i_job.sum) : ACC_W'(i_job.sum);
        mag_den = i_job.total[ACC_W-1] ? ACC_W'(-i_job.total) : ACC_W'(i_job.total);
        // A negative mean may reach the most negative value, a positive one not.
        limit   = r_neg ? ACC_MIN : ACC_MAX;
        q_ovf   = r_num > NUM_W'(limit);
        q_sat   = q_ovf ? limit : r_num[ACC_W-1:0];
    end

    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_pop);

    assign o_empty       = !r_out_valid;
    assign o_mean        = r_mean;
    assign o_zero_weight = r_zw;
    assign o_overflowed  = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= (i_job.total == '0) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_num  <= NUM_W'(mag_num) << FRAC_BITS;
            r_den  <= mag_den;
            r_rem  <= '0;
            r_cnt  <= CNT_W'(NUM_W);
            r_neg  <= i_job.sum[ACC_W-1] != i_job.total[ACC_W-1];
            r_zero <= i_job.total == '0;
            r_ovf  <= i_job.sat;
        end else if (r_state == S_DIV) begin
            r_rem  <= fits ? trial[ACC_W-1:0] : rem_sh[ACC_W-1:0];
            r_num  <= {r_num[NUM_W-2:0], fits};
            r_cnt  <= r_cnt - 1'b1;
        end
        if (out_load) begin
            r_mean <= r_zero ? '0 : (r_neg ? ACC_W'(-q_sat) : q_sat);
            r_zw   <= r_zero;
            r_ov   <= r_ovf || (!r_zero && q_ovf);
        end
    end

endmodule

[verif/tb_weighted_mean_accumulator.sv]
// ----------------------------------------------------------------------------
// Weighted mean accumulator testbench
// Streams vectors of (weight, value) items into the block and predicts each
// weighted mean with full-width integer arithmetic. Results are checked in
// order against the prediction while both sides idle at random. The run
// starts with hand-picked vectors for the saturation and zero-weight cases.
// A long receiver stall part way through forces the input side to back up.
// ----------------------------------------------------------------------------
module tb_weighted_mean_accumulator;
    import wma_pkg::*;

    localparam int PERIOD         = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int MAX_GAP        = 12;
    localparam int LONG_STALL     = 400;
    localparam int DRAIN_CYCLES   = 120;
    localparam int TIMEOUT_CYCLES = 3_000_000;

    localparam logic [IN_W-1:0] FIELD_MAX = 32'h7fff_ffff;
    localparam logic [IN_W-1:0] FIELD_MIN = 32'h8000_0000;
    localparam logic [IN_W-1:0] NEAR_MIN  = 32'h8000_0002;

    typedef struct {
        t_acc mean;
        logic zero_weight;
        logic overflowed;
    } t_mean_result;

    // Keeps its own copy of the running sums and the means still owed.
    class mean_tracker;
        t_acc         product_sum  = '0;
        t_acc         weight_total = '0;
        logic         saturated    = 1'b0;
        t_mean_result expected_means[$];
        int           mismatches   = 0;

        function void clear_sums();
            product_sum  = '0;
            weight_total = '0;
            saturated    = 1'b0;
        endfunction

        function t_acc add_clamped(t_acc a, t_acc b);
            logic [ACC_W:0] s;
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1]) begin
                saturated = 1'b1;
                return s[ACC_W] ? ACC_MIN : ACC_MAX;
            end
            return s[ACC_W-1:0];
        endfunction

        // Exact (num * 2^FRAC_BITS) / den on magnitudes, truncated towards zero.
        function t_acc fixed_quotient(t_acc num, t_acc den, output logic clamped);
            logic [ACC_W-1:0]   n_mag;
            logic [ACC_W-1:0]   d_mag;
            logic [2*ACC_W-1:0] q;
            logic [2*ACC_W-1:0] limit;
            logic               negative;
            n_mag    = num[ACC_W-1] ? -num : num;
            d_mag    = den[ACC_W-1] ? -den : den;
            negative = num[ACC_W-1] != den[ACC_W-1];
            q = ({{ACC_W{1'b0}}, n_mag} << FRAC_BITS) / {{ACC_W{1'b0}}, d_mag};
            limit = (128'd1 << (ACC_W - 1)) - (negative ? 128'd0 : 128'd1);
            clamped = 1'b0;
            if (q > limit) begin
                clamped = 1'b1;
                q = limit;
            end
            return negative ? -q[ACC_W-1:0] : q[ACC_W-1:0];
        endfunction

        function void take_item(logic [IN_W-1:0] w_raw, logic [IN_W-1:0] v_raw,
                                logic closes);
            t_acc         w;
            t_acc         v;
            t_mean_result r;
            logic         clamped;
            w = $signed(w_raw[DATA_WIDTH-1:0]);
            v = $signed(v_raw[DATA_WIDTH-1:0]);
            product_sum  = add_clamped(product_sum, w * v);
            weight_total = add_clamped(weight_total, w);
            if (!closes)
                return;
            r.overflowed = saturated;
            if (weight_total == '0) begin
                r.mean        = '0;
                r.zero_weight = 1'b1;
            end else begin
                r.mean        = fixed_quotient(product_sum, weight_total, clamped);
                r.zero_weight = 1'b0;
                r.overflowed  = r.overflowed | clamped;
            end
            expected_means.push_back(r);
            clear_sums();
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_mean(t_acc mean, logic zero_weight, logic overflowed);
            t_mean_result e;
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("result with none owed, mean %0d", mean));
                return;
            end
            e = expected_means.pop_front();
            if (mean !== e.mean)
                report_mismatch($sformatf("mean %0d, wanted %0d", mean, e.mean));
            if (zero_weight !== e.zero_weight)
                report_mismatch($sformatf("zero_weight %b, wanted %b",
                                          zero_weight, e.zero_weight));
            if (overflowed !== e.overflowed)
                report_mismatch($sformatf("overflowed %b, wanted %b",
                                          overflowed, e.overflowed));
        endtask
    endclass

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            push           = 1'b0;
    logic            pop            = 1'b0;
    logic [IN_W-1:0] i_weight       = '0;
    logic [IN_W-1:0] i_sample_value = '0;
    logic            i_last         = 1'b0;
    logic            full;
    logic            empty;
    t_acc            o_mean;
    logic            o_zero_weight;
    logic            o_overflowed;

    int          send_idle_pct = 0;
    int          rcv_idle_pct  = 0;
    int          items_sent    = 0;
    int          stall_order   = 0;
    bit          running       = 1'b0;
    mean_tracker tracker       = new;

    weighted_mean_accumulator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_weight       (i_weight),
        .i_sample_value (i_sample_value),
        .i_last         (i_last),
        .empty          (empty),
        .pop            (pop),
        .o_mean         (o_mean),
        .o_zero_weight  (o_zero_weight),
        .o_overflowed   (o_overflowed)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    // Push stays high between back-to-back items; it drops only for a gap.
    task automatic send_item(logic [IN_W-1:0] w, logic [IN_W-1:0] v, logic closes);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_weight       <= w;
        i_sample_value <= v;
        i_last         <= closes;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        tracker.take_item(w, v, closes);
        items_sent++;
    endtask

    function automatic logic [IN_W-1:0] random_field();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0: return 32'($signed($urandom_range(200)) - 100);
            1: return 32'($urandom_range(15));
            2: begin
                case ($urandom_range(4))
                    0: return FIELD_MAX;
                    1: return FIELD_MIN;
                    2: return '1;
                    3: return 32'd1;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Some vectors get a closing weight that brings the total back to zero.
    task automatic send_random_vector(int max_len);
        int              len;
        bit              balance;
        longint          wsum;
        logic [IN_W-1:0] w;
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, max_len);
        balance = ($urandom_range(9) == 0);
        wsum = 0;
        for (int k = 0; k < len; k++) begin
            w = random_field();
            if (balance && k == len - 1 && wsum <= 64'sd2147483648 && wsum >= -64'sd2147483647)
                w = 32'(-wsum);
            wsum += longint'($signed(w));
            send_item(w, random_field(), k == len - 1);
        end
    endtask

    task automatic send_directed();
        // A lone closing item is a vector of one.
        send_item(3, 7, 1'b1);
        send_item(FIELD_MAX, FIELD_MAX, 1'b0);
        send_item(FIELD_MIN, FIELD_MIN, 1'b0);
        send_item(FIELD_MIN, FIELD_MAX, 1'b1);
        // Weights that cancel give the zero-weight flag.
        send_item(5, 100, 1'b0);
        send_item(-5, 3, 1'b1);
        send_item(0, 123, 1'b1);
        // The sum of products runs past the top, then past the bottom.
        send_item(FIELD_MIN, FIELD_MIN, 1'b0);
        send_item(FIELD_MIN, FIELD_MIN, 1'b0);
        send_item(1, 0, 1'b1);
        send_item(FIELD_MIN, FIELD_MAX, 1'b0);
        send_item(FIELD_MIN, FIELD_MAX, 1'b0);
        send_item(FIELD_MIN, FIELD_MAX, 1'b0);
        send_item(2, -9, 1'b1);
        // A total weight of one with a huge sum makes the quotient clamp.
        send_item(FIELD_MAX, FIELD_MAX, 1'b0);
        send_item(NEAR_MIN, 0, 1'b1);
        send_item(FIELD_MAX, FIELD_MIN, 1'b0);
        send_item(NEAR_MIN, 0, 1'b1);
        // Zero total weight after the sum has saturated still reports overflow.
        send_item(FIELD_MIN, FIELD_MIN, 1'b0);
        send_item(FIELD_MIN, FIELD_MIN, 1'b0);
        send_item(FIELD_MAX, 0, 1'b0);
        send_item(FIELD_MAX, 0, 1'b0);
        send_item(2, 0, 1'b1);
        // A negative quotient is truncated towards zero.
        send_item(3, -1, 1'b0);
        send_item(4, 0, 1'b1);
    endtask

    // Receiver: checks each popped result and serves long stalls on request.
    initial begin
        int stall_seen;
        int stall_left;
        stall_seen = 0;
        stall_left = 0;
        wait (running);
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                tracker.check_mean(o_mean, o_zero_weight, o_overflowed);
            if (stall_seen != stall_order) begin
                stall_seen = stall_order;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        send_idle_pct = 23;
        rcv_idle_pct  = 86;
        send_directed();
        while (items_sent < 550)
            send_random_vector(8);

        send_idle_pct = 86;
        rcv_idle_pct  = 23;
        while (items_sent < 1050)
            send_random_vector(8);

        // Short vectors against a stalled receiver fill the block up.
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        stall_order <= stall_order + 1;
        while (items_sent < 1300)
            send_random_vector(2);
        while (items_sent < 1650)
            send_random_vector(8);
        push <= 1'b0;

        while (tracker.expected_means.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_means.size() == 0)
            $display("weighted_mean_accumulator regression: pass");
        else
            $display("weighted_mean_accumulator regression: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * PERIOD);
        $display("weighted_mean_accumulator regression: fail");
        $finish;
    end

endmodule

[filelist.f]
src/wma_pkg.sv
src/wma_front.sv
src/wma_fifo.sv
src/wma_divider.sv
src/weighted_mean_accumulator.sv
verif/tb_weighted_mean_accumulator.sv
